@@ sv/avd_pkg.sv @@
// ----------------------------------------------------------------------------
// avd_pkg
// mode codes, internal precision and the exponential constant generator
// ----------------------------------------------------------------------------
package avd_pkg;

    localparam int QB = 32;

    localparam logic [2:0] MODE_LINEAR  = 3'd0;
    localparam logic [2:0] MODE_SIGMOID = 3'd1;
    localparam logic [2:0] MODE_RELU    = 3'd2;
    localparam logic [2:0] MODE_TANH    = 3'd3;
    localparam logic [2:0] MODE_QUAD    = 3'd4;

    // e^-(2^m) in unsigned Q32, elaboration time only
    // series for e^-(2^-32) in Q124, then squared up to e^-(2^m)
    function automatic logic [QB-1:0] exp_const(input int m);
        logic [255:0] p;
        logic [127:0] sum;
        logic [128:0] r;
        int           n;
        sum = (128'd1 << 124) - (128'd1 << 92) + (128'd1 << 59) - 128'd44739243;
        for (n = 0; n < m + 32; n++) begin
            p   = {128'd0, sum} * {128'd0, sum};
            sum = p[251:124];
        end
        r = ({1'b0, sum} + (129'd1 << 91)) >> 92;
        if (r > 129'hFFFF_FFFF) begin
            return {QB{1'b1}};
        end
        return r[QB-1:0];
    endfunction

endpackage

@@ sv/avd_exp.sv @@
// ----------------------------------------------------------------------------
// avd_exp
// e^-y by a chain of constant multiplies, one input bit per stage
// ----------------------------------------------------------------------------
module avd_exp
    import avd_pkg::*;
#(
    parameter int YW = 17,
    parameter int FB = 12,
    parameter int SW = 52
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [YW-1:0] in_y,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QB:0]   out_u,
    output logic [SW-1:0] out_side
);

    logic [YW-1:0] v_reg;
    logic [QB:0]   u_reg    [YW];
    logic [YW-1:0] y_reg    [YW];
    logic [SW-1:0] side_reg [YW];

    genvar j;
    generate
        for (j = 0; j < YW; j++) begin : g_stage
            localparam logic [QB-1:0] EK = exp_const(j - FB);
            logic             cur_v;
            logic [QB:0]      cur_u;
            logic [YW-1:0]    cur_y;
            logic [SW-1:0]    cur_side;
            logic [2*QB:0]    prod;
            if (j == 0) begin : g_first
                assign cur_v    = in_valid;
                assign cur_u    = {1'b1, {QB{1'b0}}};
                assign cur_y    = in_y;
                assign cur_side = in_side;
            end else begin : g_next
                assign cur_v    = v_reg[j-1];
                assign cur_u    = u_reg[j-1];
                assign cur_y    = y_reg[j-1];
                assign cur_side = side_reg[j-1];
            end
            assign prod = cur_u * {1'b0, EK};
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (en) begin
                    v_reg[j] <= cur_v;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    u_reg[j]    <= cur_y[j] ? prod[2*QB:QB] : cur_u;
                    y_reg[j]    <= cur_y;
                    side_reg[j] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[YW-1];
    assign out_u     = u_reg[YW-1];
    assign out_side  = side_reg[YW-1];

endmodule

@@ sv/avd_div.sv @@
// ----------------------------------------------------------------------------
// avd_div
// pipelined restoring divider, one quotient bit per stage, q = n / d in Q32
// ----------------------------------------------------------------------------
module avd_div
    import avd_pkg::*;
#(
    parameter int SW = 52
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [QB+1:0] in_n,
    input  logic [QB+1:0] in_d,
    input  logic [SW-1:0] in_side,
    output logic          out_valid,
    output logic [QB:0]   out_q,
    output logic [SW-1:0] out_side
);

    localparam int NS = QB + 1;

    logic [NS-1:0] v_reg;
    logic [QB+1:0] rem_reg  [NS];
    logic [QB+1:0] d_reg    [NS];
    logic [QB:0]   q_reg    [NS];
    logic [SW-1:0] side_reg [NS];

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_stage
            logic          cur_v;
            logic [QB+2:0] cur_rem;
            logic [QB+1:0] cur_d;
            logic [QB:0]   cur_q;
            logic [SW-1:0] cur_side;
            logic          bit_w;
            logic [QB+2:0] diff;
            if (j == 0) begin : g_first
                assign cur_v    = in_valid;
                assign cur_rem  = {1'b0, in_n};
                assign cur_d    = in_d;
                assign cur_q    = '0;
                assign cur_side = in_side;
            end else begin : g_next
                assign cur_v    = v_reg[j-1];
                assign cur_rem  = {rem_reg[j-1], 1'b0};
                assign cur_d    = d_reg[j-1];
                assign cur_q    = q_reg[j-1];
                assign cur_side = side_reg[j-1];
            end
            assign bit_w = (cur_rem >= {1'b0, cur_d});
            assign diff  = cur_rem - {1'b0, cur_d};
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[j] <= 1'b0;
                end else if (en) begin
                    v_reg[j] <= cur_v;
                end
            end
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[j]  <= bit_w ? diff[QB+1:0] : cur_rem[QB+1:0];
                    d_reg[j]    <= cur_d;
                    q_reg[j]    <= {cur_q[QB-1:0], bit_w};
                    side_reg[j] <= cur_side;
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[NS-1];
    assign out_q     = q_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

@@ sv/activation_with_derivative.sv @@
// ----------------------------------------------------------------------------
// activation_with_derivative
// activation and derivative of a fixed-point sample: linear, sigmoid, relu,
// tanh or quadratic, rounded and saturated
// ----------------------------------------------------------------------------
// channel   dir  fields (low bit first)
// s_axis    in   tdata: sample
// m_axis    out  tdata: activation, derivative
// cfg       in   cfg_wdata: mode
//
// one word per cycle unless m_tready stalls; path: front stage, exponential chain
// (one stage per input bit), divider (one bit per stage), product and output stage
// synchronous active-low reset clears all valid bits and sets mode to linear
// a stall on m_tready freezes the whole pipe; s_tready follows it directly
module activation_with_derivative
    import avd_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 12
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [2:0]                            cfg_wdata,  // mode
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]       s_tdata,    // sample
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [((2*DATA_WIDTH+7)/8)*8-1:0]     m_tdata     // activation, derivative
);

    localparam int DW  = DATA_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int YW  = DW + 1;
    localparam int SW  = 3 + 1 + DW + 2 * DW;
    localparam int WW  = (2 * DW + 2 > FB + 3) ? 2 * DW + 2 : FB + 3;
    localparam int OTW = ((2 * DW + 7) / 8) * 8;

    logic [2:0] mode_reg;
    logic       en;

    // front stage
    logic                 a_v_reg;
    logic [YW-1:0]        a_y_reg;
    logic [SW-1:0]        a_side_reg;
    logic signed [DW-1:0] x_w;
    logic [DW-1:0]        mag_w;
    logic [2*DW-1:0]      sq_w;

    // chain outputs
    logic          e_v;
    logic [QB:0]   e_u;
    logic [SW-1:0] e_side;
    logic [QB+1:0] div_n;
    logic [QB+1:0] div_d;
    logic          d_v;
    logic [QB:0]   d_q;
    logic [SW-1:0] d_side;

    // product stage
    logic          mid_v_reg;
    logic [QB:0]   mid_q_reg;
    logic [QB:0]   mid_qc_reg;
    logic [QB:0]   mid_p_reg;
    logic [SW-1:0] mid_side_reg;
    logic [QB:0]   qc_w;
    logic [2*QB+1:0] prod_w;

    // output stage
    logic          out_v_reg;
    logic [DW-1:0] act_reg;
    logic [DW-1:0] der_reg;

    assign en       = !out_v_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_LINEAR;
        end else if (cfg_we) begin
            mode_reg <= cfg_wdata;
        end
    end

    assign x_w   = s_tdata[DW-1:0];
    assign mag_w = x_w[DW-1] ? (~s_tdata[DW-1:0] + 1'b1) : s_tdata[DW-1:0];
    assign sq_w  = mag_w * mag_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (en) begin
            a_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_y_reg    <= (mode_reg == MODE_TANH) ? {mag_w, 1'b0} : {1'b0, mag_w};
            a_side_reg <= {mode_reg, x_w[DW-1], s_tdata[DW-1:0], sq_w};
        end
    end

    avd_exp #(
        .YW(YW),
        .FB(FB),
        .SW(SW)
    ) u_exp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_v_reg),
        .in_y     (a_y_reg),
        .in_side  (a_side_reg),
        .out_valid(e_v),
        .out_u    (e_u),
        .out_side (e_side)
    );

    assign div_d = {1'b0, 1'b1, {QB{1'b0}}} + {1'b0, e_u};
    assign div_n = (e_side[SW-1 -: 3] == MODE_SIGMOID) ? {2'b01, {QB{1'b0}}}
                 : ({2'b01, {QB{1'b0}}} - {1'b0, e_u});

    avd_div #(
        .SW(SW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (e_v),
        .in_n     (div_n),
        .in_d     (div_d),
        .in_side  (e_side),
        .out_valid(d_v),
        .out_q    (d_q),
        .out_side (d_side)
    );

    assign qc_w   = {1'b1, {QB{1'b0}}} - d_q;
    assign prod_w = (d_side[SW-1 -: 3] == MODE_SIGMOID) ? d_q * qc_w : d_q * d_q;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_v_reg <= 1'b0;
        end else if (en) begin
            mid_v_reg <= d_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mid_q_reg    <= d_q;
            mid_qc_reg   <= qc_w;
            mid_p_reg    <= prod_w[2*QB:QB];
            mid_side_reg <= d_side;
        end
    end

    // final selection, rounding and saturation
    logic [2:0]           f_mode;
    logic                 f_neg;
    logic signed [DW-1:0] f_x;
    logic [2*DW-1:0]      f_sq;
    logic [QB+1:0]        act_q;
    logic [QB+1:0]        der_q;
    logic [QB+1:0]        act_rnd;
    logic [QB+1:0]        der_rnd;
    logic signed [WW-1:0] x_wide;
    logic signed [WW-1:0] unit_wide;
    logic signed [WW-1:0] act_wide;
    logic signed [WW-1:0] der_wide;
    logic signed [WW-1:0] sat_hi;
    logic signed [WW-1:0] sat_lo;
    logic [DW-1:0]        act_next;
    logic [DW-1:0]        der_next;

    assign f_mode = mid_side_reg[SW-1 -: 3];
    assign f_neg  = mid_side_reg[SW-4];
    assign f_x    = mid_side_reg[3*DW-1 -: DW];
    assign f_sq   = mid_side_reg[2*DW-1:0];

    assign act_q = (f_mode == MODE_SIGMOID && f_neg) ? {1'b0, mid_qc_reg} : {1'b0, mid_q_reg};
    assign der_q = (f_mode == MODE_SIGMOID) ? {1'b0, mid_p_reg}
                 : ({2'b01, {QB{1'b0}}} - {1'b0, mid_p_reg});
    assign act_rnd = (act_q + ((QB+2)'(1) << (QB - 1 - FB))) >> (QB - FB);
    assign der_rnd = (der_q + ((QB+2)'(1) << (QB - 1 - FB))) >> (QB - FB);

    assign x_wide    = WW'(f_x);
    assign unit_wide = WW'(1) << FB;
    assign sat_hi    = (WW'(1) << (DW - 1)) - WW'(1);
    assign sat_lo    = -sat_hi - WW'(1);

    always_comb begin
        case (f_mode)
            MODE_SIGMOID: begin
                act_wide = WW'(act_rnd);
                der_wide = WW'(der_rnd);
            end
            MODE_RELU: begin
                act_wide = (x_wide > 0) ? x_wide : '0;
                der_wide = (x_wide > 0) ? unit_wide : '0;
            end
            MODE_TANH: begin
                act_wide = f_neg ? -WW'(act_rnd) : WW'(act_rnd);
                der_wide = WW'(der_rnd);
            end
            MODE_QUAD: begin
                act_wide = WW'(({1'b0, f_sq} + ((2*DW+1)'(1) << (FB - 1))) >> FB);
                der_wide = x_wide <<< 1;
            end
            default: begin
                act_wide = x_wide;
                der_wide = unit_wide;
            end
        endcase
    end

    assign act_next = (act_wide > sat_hi) ? sat_hi[DW-1:0]
                    : (act_wide < sat_lo) ? sat_lo[DW-1:0] : act_wide[DW-1:0];
    assign der_next = (der_wide > sat_hi) ? sat_hi[DW-1:0]
                    : (der_wide < sat_lo) ? sat_lo[DW-1:0] : der_wide[DW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (en) begin
            out_v_reg <= mid_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            act_reg <= act_next;
            der_reg <= der_next;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OTW'({der_reg, act_reg});

    // pipe frees the input whenever the output holds nothing
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // a new output word comes only from the product stage
    a_out_from_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(mid_v_reg))
        else $error("output word without source");

    // reset empties the pipe
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !mid_v_reg)
        else $error("valid after reset");

endmodule

@@ dv/activation_with_derivative_chk.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// activation_with_derivative_chk
// watches the sample and result streams and the mode write port, works out
// the activation and derivative of every accepted sample in 64-bit fixed
// point and compares each result word in order, field by field
// ----------------------------------------------------------------------------
module activation_with_derivative_chk
    import avd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          errors,
    output int          pending
);

    localparam logic [63:0] ONE_Q62  = 64'd1 << 62;
    localparam logic [63:0] LN2_Q56  = 64'h00B1_7217_F7D1_CF7A;

    typedef struct packed {
        logic [15:0] act;
        logic [15:0] der;
    } act_pair_t;

    logic [2:0] cur_mode;
    act_pair_t  expected_pairs[$];

    function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    function automatic logic [63:0] qdiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        if (d == 0) begin
            return ONE_Q62;
        end
        q   = (n >= d) ? 64'd1 : 64'd0;
        rem = (n >= d) ? n - d : n;
        for (int i = 0; i < 62; i++) begin
            rem = rem << 1;
            q   = q << 1;
            if (rem >= d) begin
                rem = rem - d;
                q   = q | 64'd1;
            end
        end
        return q;
    endfunction

    // e^-a, a with 12 fraction bits, result in Q62
    function automatic logic [63:0] exp_neg_q62(input logic [63:0] a);
        logic [63:0] y;
        logic [63:0] term;
        logic [63:0] acc;
        int          k;
        k = 0;
        if ((a >> 12) >= 64) begin
            return 64'd0;
        end
        y = a << 44;
        while (y >= LN2_Q56) begin
            y = y - LN2_Q56;
            k++;
        end
        y    = y << 6;
        term = ONE_Q62;
        acc  = ONE_Q62;
        for (int n = 1; n <= 30; n++) begin
            term = qmul(term, y) / n;
            if (n % 2 == 1) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        if (k >= 64) begin
            return 64'd0;
        end
        return acc >> k;
    endfunction

    function automatic longint round_q12(input logic [63:0] v);
        logic [63:0] r;
        r = (v + (64'd1 << 49)) >> 50;
        return longint'(r);
    endfunction

    function automatic logic [15:0] sat16(input longint v);
        if (v > 32767) begin
            return 16'h7FFF;
        end
        if (v < -32768) begin
            return 16'h8000;
        end
        return v[15:0];
    endfunction

    function automatic act_pair_t activation_of(input logic [2:0] md, input logic [15:0] raw);
        longint      x;
        logic [63:0] mag;
        logic [63:0] u;
        logic [63:0] sp;
        logic [63:0] t;
        longint      a;
        longint      d;
        longint      tm;
        act_pair_t   res;
        x   = longint'($signed(raw));
        mag = (x < 0) ? 64'(-x) : 64'(x);
        case (md)
            MODE_SIGMOID: begin
                u  = exp_neg_q62(mag);
                sp = qdiv(ONE_Q62, ONE_Q62 + u);
                a  = round_q12(x >= 0 ? sp : ONE_Q62 - sp);
                d  = round_q12(qmul(sp, ONE_Q62 - sp));
            end
            MODE_RELU: begin
                a = (x > 0) ? x : 0;
                d = (x > 0) ? 4096 : 0;
            end
            MODE_TANH: begin
                u  = exp_neg_q62(mag * 2);
                t  = qdiv(ONE_Q62 - u, ONE_Q62 + u);
                tm = round_q12(t);
                a  = (x < 0) ? -tm : tm;
                d  = round_q12(ONE_Q62 - qmul(t, t));
            end
            MODE_QUAD: begin
                a = longint'((mag * mag + 64'd2048) >> 12);
                d = 2 * x;
            end
            default: begin
                a = x;
                d = 4096;
            end
        endcase
        res.act = sat16(a);
        res.der = sat16(d);
        return res;
    endfunction

    always @(posedge aclk) begin
        act_pair_t want;
        if (!aresetn) begin
            cur_mode = MODE_LINEAR;
            expected_pairs.delete();
            errors = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_pairs.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected word act=%h der=%h", $time,
                             m_tdata[15:0], m_tdata[31:16]);
                end else begin
                    want = expected_pairs.pop_front();
                    if (m_tdata[15:0] !== want.act) begin
                        errors++;
                        $display("%0t: activation expected %h actual %h", $time,
                                 want.act, m_tdata[15:0]);
                    end
                    if (m_tdata[31:16] !== want.der) begin
                        errors++;
                        $display("%0t: derivative expected %h actual %h", $time,
                                 want.der, m_tdata[31:16]);
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_pairs.push_back(activation_of(cur_mode, s_tdata));
            end
            if (cfg_we) begin
                cur_mode = cfg_wdata;
            end
        end
        pending = expected_pairs.size();
    end

endmodule

@@ dv/activation_with_derivative_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// activation_with_derivative_tb
// drives samples through every mode, including the unused codes, with
// directed extremes and random values, random idling on both streams in the first
// eight phases, a long receiver hold-off and a drain pause; the checker gives the verdict
// ----------------------------------------------------------------------------
module activation_with_derivative_tb;
    import avd_pkg::*;

    localparam logic [2:0] MODE_SPARE5 = 3'd5;
    localparam logic [2:0] MODE_SPARE6 = 3'd6;
    localparam logic [2:0] MODE_SPARE7 = 3'd7;
    localparam int DRAIN_CYCLES = 80;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int NUM_PHASES   = 12;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    int          errors;
    int          pending;
    int          tx_idle_pct;
    int          rx_idle_pct;
    logic        hold_req;
    int          cycles;

    activation_with_derivative u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    activation_with_derivative_chk u_chk (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        int hold_cnt;
        m_tready = 1'b0;
        hold_cnt = 0;
        forever begin
            @(posedge aclk);
            if (hold_req && hold_cnt == 0) begin
                hold_cnt = 300;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic send_sample(input logic [15:0] v);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= v;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_mode(input logic [2:0] md);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= md;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    logic [2:0]  phase_modes[NUM_PHASES];
    logic [15:0] corner_vals[14];

    initial begin
        logic [15:0] v;
        phase_modes = '{MODE_LINEAR, MODE_SIGMOID, MODE_RELU, MODE_TANH, MODE_QUAD,
                        MODE_SPARE5, MODE_SPARE6, MODE_SPARE7, MODE_SIGMOID,
                        MODE_TANH, MODE_QUAD, MODE_LINEAR};
        corner_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h1000,
                        16'hF000, 16'h5555, 16'hAAAA, 16'h0B50, 16'hF4B0, 16'h0800,
                        16'h2000, 16'hE000};
        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_wdata   = MODE_LINEAR;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        hold_req    = 1'b0;
        tx_idle_pct = 34;
        rx_idle_pct = 55;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int p = 0; p < NUM_PHASES; p++) begin
            // mode 0 comes from reset in the first phase
            if (p > 0) begin
                write_mode(phase_modes[p]);
            end
            if (p >= 8) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (p >= 4) begin
                tx_idle_pct = 55;
                rx_idle_pct = 34;
            end
            foreach (corner_vals[i]) begin
                send_sample(corner_vals[i]);
            end
            for (int n = 0; n < 66; n++) begin
                if (p == 2 && n == 10) begin
                    hold_req <= 1'b1;
                end else if (p == 2 && n == 11) begin
                    hold_req <= 1'b0;
                end
                if (p == 6 && n == 30) begin
                    wait_drained();
                end
                if ($urandom_range(1)) begin
                    v = $urandom_range(16'hFFFF);
                end else begin
                    v = 16'($signed($urandom_range(16'h7FFF)) - 16'sh4000);
                end
                send_sample(v);
            end
        end
        s_tvalid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
